// File: sv/ilni_pkg.sv
// Shared constants for the indexed list store: field widths, request kinds,
// status codes and parameter defaults. No dependencies.
package ilni_pkg;

   localparam int KIND_BITS      = 2;
   localparam int POS_BITS       = 7;
   localparam int STATUS_BITS    = 2;
   localparam int DEF_CAPACITY   = 64;
   localparam int DEF_VALUE_BITS = 32;

   localparam logic [KIND_BITS-1:0] KIND_APPEND = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_POP    = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_READ   = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

endpackage

// File: sv/ilni_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
// No dependencies.
module ilni_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/indexed_list_with_negative_index.sv
// Top level of the indexed list store: request sequencer, index resolution and
// element shifting over one RAM. Depends on ilni_pkg and ilni_ram.
//
//  channel | direction | tuser          | tdata (lowest bit up)
//  req_    | in        | kind           | position, item_value, zero pad
//  rsp_    | out       | status         | read_value, length, zero pad
//
// Append, the unused kind and any rejected request step through S_RESOLVE and S_DONE;
// read adds S_FETCH, and pop adds S_FETCH then S_SHIFT, where the shift moves one
// RAM entry per cycle for each element behind the popped one.
// Reset empties the list at once; stored contents are not cleared.
// A finished response waits in the output register; the next request is taken
// while it waits, and the sequencer holds in its final step until it drains.
module indexed_list_with_negative_index
   import ilni_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int VALUE_BITS = DEF_VALUE_BITS,
   localparam int CNT_BITS      = $clog2(CAPACITY + 1),
   localparam int REQ_DATA_BITS = ((POS_BITS + VALUE_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_BITS = ((VALUE_BITS + CNT_BITS + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // position, item_value
   input  logic [KIND_BITS-1:0]     req_tuser,   // kind
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // read_value, length
   output logic [STATUS_BITS-1:0]   rsp_tuser    // status
);

   localparam int ADDR_BITS = $clog2(CAPACITY);
   localparam int RES_BITS  = ((CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS) + 1;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_RESOLVE = 3'd1;
   localparam logic [2:0] S_FETCH   = 3'd2;
   localparam logic [2:0] S_SHIFT   = 3'd3;
   localparam logic [2:0] S_DONE    = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic [KIND_BITS-1:0]     kind_ff, kind_in;
   logic signed [POS_BITS-1:0] pos_ff, pos_in;
   logic [VALUE_BITS-1:0]    value_ff, value_in;
   logic [CNT_BITS-1:0]      count_ff, count_in;
   logic [CNT_BITS-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]      wr_ptr_ff, wr_ptr_in;
   logic                     pend_ff, pend_in;
   logic [VALUE_BITS-1:0]    result_ff, result_in;
   logic [STATUS_BITS-1:0]   status_ff, status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]    rsp_value_ff, rsp_value_in;
   logic [STATUS_BITS-1:0]   rsp_status_ff, rsp_status_in;
   logic [CNT_BITS-1:0]      rsp_length_ff, rsp_length_in;

   logic                     ram_we;
   logic [ADDR_BITS-1:0]     ram_waddr;
   logic [VALUE_BITS-1:0]    ram_wdata;
   logic [ADDR_BITS-1:0]     ram_raddr;
   logic [VALUE_BITS-1:0]    ram_rdata;

   logic signed [RES_BITS-1:0] pos_ext, cnt_ext, sum;
   logic                     idx_ok;
   logic [CNT_BITS-1:0]      slot;
   logic                     req_fire;
   logic                     more;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      pos_ext = RES_BITS'(pos_ff);
      cnt_ext = signed'(RES_BITS'(count_ff));
      sum     = cnt_ext + pos_ext;
      if (pos_ext[RES_BITS-1]) begin
         idx_ok = !sum[RES_BITS-1];
         slot   = CNT_BITS'(sum);
      end else begin
         idx_ok = (pos_ext < cnt_ext);
         slot   = CNT_BITS'(pos_ext);
      end
   end

   assign more = (rd_ptr_ff < count_ff);

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      pos_in        = pos_ff;
      value_in      = value_ff;
      count_in      = count_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      pend_in       = pend_ff;
      result_in     = result_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_length_in = rsp_length_ff;
      ram_we        = 1'b0;
      ram_waddr     = wr_ptr_ff[ADDR_BITS-1:0];
      ram_wdata     = ram_rdata;
      ram_raddr     = rd_ptr_ff[ADDR_BITS-1:0];

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               kind_in   = req_tuser;
               pos_in    = signed'(req_tdata[POS_BITS-1:0]);
               value_in  = req_tdata[POS_BITS +: VALUE_BITS];
               result_in = '0;
               status_in = ST_OK;
               state_in  = S_RESOLVE;
            end
         end
         S_RESOLVE: begin
            state_in = S_DONE;
            case (kind_ff)
               KIND_APPEND: begin
                  if (count_ff == CNT_BITS'(CAPACITY)) begin
                     status_in = ST_FULL;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = count_ff[ADDR_BITS-1:0];
                     ram_wdata = value_ff;
                     count_in  = count_ff + 1'b1;
                  end
               end
               KIND_POP, KIND_READ: begin
                  if (!idx_ok) begin
                     status_in = ST_RANGE;
                  end else begin
                     ram_raddr = slot[ADDR_BITS-1:0];
                     rd_ptr_in = slot + 1'b1;
                     wr_ptr_in = slot;
                     state_in  = S_FETCH;
                  end
               end
               default: begin
                  status_in = ST_OK;
               end
            endcase
         end
         S_FETCH: begin
            result_in = ram_rdata;
            pend_in   = 1'b0;
            state_in  = (kind_ff == KIND_POP) ? S_SHIFT : S_DONE;
         end
         S_SHIFT: begin
            pend_in = more;
            if (more) begin
               rd_ptr_in = rd_ptr_ff + 1'b1;
            end
            if (pend_ff) begin
               ram_we    = 1'b1;
               wr_ptr_in = wr_ptr_ff + 1'b1;
            end
            if (!more && !pend_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = result_ff;
               rsp_status_in = status_ff;
               rsp_length_in = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      pos_ff        <= pos_in;
      value_ff      <= value_in;
      rd_ptr_ff     <= rd_ptr_in;
      wr_ptr_ff     <= wr_ptr_in;
      result_ff     <= result_in;
      status_ff     <= status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_length_ff <= rsp_length_in;
   end

   ilni_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[VALUE_BITS-1:0] = rsp_value_ff;
      rsp_tdata[VALUE_BITS +: CNT_BITS] = rsp_length_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(CAPACITY))
      else $error("element count above capacity");

   a_accept_resolve: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_RESOLVE)
      else $error("accepted request not resolved next cycle");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && ram_we) |-> wr_ptr_ff < count_ff)
      else $error("shift writes beyond the list");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |->
      (count_ff == CNT_BITS'($past(count_ff) + 1'b1) ||
       CNT_BITS'(count_ff + 1'b1) == $past(count_ff)))
      else $error("element count moved by more than one");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside the final step");
`endif

endmodule

// File: sim/indexed_list_with_negative_index_tb.sv
// Self-checking bench for the indexed list store: named tests drive requests on the
// req_ stream and a shadow list predicts each response checked on the rsp_ stream.
// Depends on ilni_pkg and indexed_list_with_negative_index.
module indexed_list_with_negative_index_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ilni_pkg::*;

   localparam int VAL_W = DEF_VALUE_BITS;
   localparam int CNT_W = $clog2(DEF_CAPACITY + 1);
   localparam int REQ_W = ((POS_BITS + VAL_W + 7) / 8) * 8;
   localparam int RSP_W = ((VAL_W + CNT_W + 7) / 8) * 8;
   localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 100;

   typedef struct packed {
      logic [VAL_W-1:0]       value;
      logic [STATUS_BITS-1:0] status;
      logic [CNT_W-1:0]       length;
   } list_rsp_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata = '0;   // position, item_value
   logic [KIND_BITS-1:0]   req_tuser = '0;   // kind
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_W-1:0]       rsp_tdata;        // read_value, length
   logic [STATUS_BITS-1:0] rsp_tuser;        // status

   logic [VAL_W-1:0] shadow_items [DEF_CAPACITY];
   int               shadow_count = 0;
   list_rsp_type     pending_rsp [$];
   int               fail_count = 0;
   int               quiet_cycles = 0;
   bit               idle_on = 1'b1;
   int               stall_left = 0;

   indexed_list_with_negative_index u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   function automatic list_rsp_type list_apply(input logic [KIND_BITS-1:0] kind,
                                               input logic signed [POS_BITS-1:0] pos,
                                               input logic [VAL_W-1:0] val);
      list_rsp_type r;
      int           p;
      int           slot;
      bit           hit;
      r    = '0;
      p    = pos;
      slot = 0;
      hit  = 1'b0;
      case (kind)
         KIND_APPEND: begin
            if (shadow_count >= DEF_CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               shadow_items[shadow_count] = val;
               shadow_count++;
            end
         end
         KIND_POP, KIND_READ: begin
            if (p >= 0 && p < shadow_count) begin
               slot = p;
               hit  = 1'b1;
            end else if (p < 0 && -p <= shadow_count) begin
               slot = shadow_count + p;
               hit  = 1'b1;
            end
            if (!hit) begin
               r.status = ST_RANGE;
            end else begin
               r.value = shadow_items[slot];
               if (kind == KIND_POP) begin
                  for (int i = slot; i < shadow_count - 1; i++)
                     shadow_items[i] = shadow_items[i + 1];
                  shadow_count--;
               end
            end
         end
         default: ;
      endcase
      r.length = shadow_count[CNT_W-1:0];
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int pick_position();
      int r;
      int idx;
      r = $urandom_range(0, 99);
      if (shadow_count > 0 && r < 70) begin
         idx = $urandom_range(0, 2 * shadow_count - 1);
         return (idx < shadow_count) ? idx : idx - 2 * shadow_count;
      end
      if (r < 82) begin
         case ($urandom_range(0, 3))
            0: return shadow_count;
            1: return -shadow_count - 1;
            2: return 63;
            default: return -64;
         endcase
      end
      return int'($urandom_range(0, 127)) - 64;
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      if ($urandom_range(0, 99) < 10) begin
         case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return {1'b1, {(VAL_W-1){1'b0}}};
            default: return 1;
         endcase
      end
      return $urandom;
   endfunction

   task automatic send_request(input logic [KIND_BITS-1:0] kind, input int pos,
                               input logic [VAL_W-1:0] val);
      int                  gap;
      logic [POS_BITS-1:0] pos_bits;
      gap      = pick_gap();
      pos_bits = pos[POS_BITS-1:0];
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_W'({val, pos_bits});
      do @(posedge clock); while (!req_tready);
      pending_rsp.push_back(list_apply(kind, pos_bits, val));
   endtask

   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic run_traffic(input int n, input int w_app, input int w_pop);
      int                   r;
      logic [KIND_BITS-1:0] kind;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 3)
            kind = KIND_UNUSED;
         else if (r < 3 + w_app)
            kind = KIND_APPEND;
         else if (r < 3 + w_app + w_pop)
            kind = KIND_POP;
         else
            kind = KIND_READ;
         send_request(kind, pick_position(), pick_value());
      end
   endtask

   task automatic test_empty_list();
      send_request(KIND_POP, 0, '1);
      send_request(KIND_READ, -1, '0);
      send_request(KIND_READ, 0, '0);
      send_request(KIND_POP, -64, '0);
      send_request(KIND_READ, 63, '0);
      send_request(KIND_UNUSED, 0, '1);
   endtask

   task automatic test_edge_values();
      send_request(KIND_APPEND, 0, 32'h0000_0000);
      send_request(KIND_APPEND, -1, 32'hFFFF_FFFF);
      send_request(KIND_APPEND, 63, 32'h8000_0000);
      send_request(KIND_APPEND, -64, 32'h7FFF_FFFF);
      send_request(KIND_APPEND, 21, 32'h5555_5555);
      send_request(KIND_READ, 0, '1);
      send_request(KIND_READ, -1, '0);
      send_request(KIND_READ, -5, '0);
      send_request(KIND_READ, 4, '0);
      send_request(KIND_READ, 5, '0);
      send_request(KIND_READ, -6, '0);
      send_request(KIND_POP, 2, '0);
      send_request(KIND_POP, -1, '0);
      send_request(KIND_POP, 0, '0);
      send_request(KIND_UNUSED, -1, '1);
   endtask

   task automatic test_single_element();
      send_request(KIND_POP, 0, '0);
      send_request(KIND_POP, -1, '0);
      send_request(KIND_READ, 0, '0);
   endtask

   task automatic test_fill_to_capacity();
      while (shadow_count < DEF_CAPACITY)
         send_request(KIND_APPEND, $urandom_range(0, 127), pick_value());
      repeat (3) send_request(KIND_APPEND, $urandom_range(0, 127), pick_value());
      send_request(KIND_READ, -64, '0);
      send_request(KIND_READ, 63, '0);
      send_request(KIND_POP, 0, '0);
      send_request(KIND_POP, -63, '0);
      send_request(KIND_APPEND, 0, pick_value());
      wait_for_responses();
   endtask

   task automatic test_random_mix();
      run_traffic(120, 60, 17);
      idle_on = 1'b0;
      run_traffic(120, 32, 32);
      idle_on = 1'b1;
      wait_for_responses();
      run_traffic(100, 15, 62);
      run_traffic(120, 35, 30);
   endtask

   task automatic report_field(input string field, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         fail_count++;
      end
   endtask

   initial begin : rsp_sink
      list_rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t: response with none expected, actual %h %h", $time,
                        rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               want = pending_rsp.pop_front();
               report_field("read_value", want.value, rsp_tdata[VAL_W-1:0]);
               report_field("status", VAL_W'(want.status), VAL_W'(rsp_tuser));
               report_field("length", VAL_W'(want.length),
                            VAL_W'(rsp_tdata[VAL_W +: CNT_W]));
            end
         end
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 99) < 20)
               stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                         : $urandom_range(8, 40);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_list();
      test_edge_values();
      test_single_element();
      test_fill_to_capacity();
      test_random_mix();
      wait_for_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_rsp.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// File: filelist.f
sv/ilni_pkg.sv
sv/ilni_ram.sv
sv/indexed_list_with_negative_index.sv
sim/indexed_list_with_negative_index_tb.sv
